### sv/hpt_pkg.sv
// Package: shared item codes for the homogeneous point transform.
package hpt_pkg;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_POINT = 1'b1
	} action_t;

	localparam int unsigned MAT_ENTRIES = 16;
	localparam int unsigned MAT_DIM     = 4;
	localparam int unsigned DIAG_STEP   = 5;

endpackage

### sv/hpt_if.sv
// Interfaces: input beat and result beat channels of the point transform.
interface hpt_in_if #(parameter int unsigned WORD_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [1:0]                   entry_row;
	logic [1:0]                   entry_col;
	logic signed [WORD_WIDTH-1:0] entry_value;
	logic signed [WORD_WIDTH-1:0] point_x;
	logic signed [WORD_WIDTH-1:0] point_y;
	logic signed [WORD_WIDTH-1:0] point_z;

	modport source (output valid, action, entry_row, entry_col, entry_value,
		point_x, point_y, point_z, input ready);
	modport sink (input valid, action, entry_row, entry_col, entry_value,
		point_x, point_y, point_z, output ready);
endinterface

interface hpt_out_if #(parameter int unsigned WORD_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [WORD_WIDTH-1:0] out_x;
	logic signed [WORD_WIDTH-1:0] out_y;
	logic signed [WORD_WIDTH-1:0] out_z;
	logic                         w_is_zero;
	logic                         saturated;

	modport source (output valid, out_x, out_y, out_z, w_is_zero, saturated,
		input ready);
	modport sink (input valid, out_x, out_y, out_z, w_is_zero, saturated,
		output ready);
endinterface

### sv/homogeneous_point_transform_top.sv
// Point beats pass product, sum, divider setup, bit step and output registers.
// One beat per cycle unless the output stalls; load beats only update the matrix.
// The depth is set by the divider lanes, which resolve one quotient bit per stage.
// The whole pipeline holds while a result waits on a stalled output.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the identity.
module homogeneous_point_transform_top
	import hpt_pkg::*;
#(
	parameter int unsigned WORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	hpt_in_if.sink    points,
	hpt_out_if.source results
);
	// full-width row sum: three products plus the scaled translation
	localparam int unsigned AW = 2*WORD_WIDTH + 2;
	// product stage, sum stage, two divider setup stages, bit steps, output
	localparam int unsigned NS = WORD_WIDTH + 5;
	localparam int unsigned WZ = WORD_WIDTH + 3;

	logic signed [WORD_WIDTH-1:0] mat_q [MAT_ENTRIES];
	logic signed [WORD_WIDTH-1:0] pt [3];
	logic signed [AW-1:0]         acc_s2 [MAT_DIM];
	logic signed [WORD_WIDTH-1:0] quo [3];
	logic [2:0]                   sat;
	logic [NS-1:0]                v_s;
	logic [WZ-1:0]                wz_s;
	logic                         adv, take;

	// advance everything unless a finished result is still waiting
	assign adv  = !v_s[NS-1] || results.ready;
	assign take = points.valid && adv;
	assign points.ready = adv;

	// matrix: a load beat writes one entry, seen by every later point beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_ENTRIES; i++) begin
				mat_q[i] <= (i % DIAG_STEP == 0)
					? WORD_WIDTH'(1) << FRAC_BITS : '0;
			end
		end else if (take && points.action == ACT_LOAD) begin
			mat_q[{points.entry_row, points.entry_col}] <= points.entry_value;
		end
	end

	// valid bits travel alongside the data; a load beat enters as a bubble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NS-2:0], points.valid && points.action == ACT_POINT};
		end
	end

	// zero w flag, taken at the sum stage and carried to the output
	always_ff @(posedge clk) begin
		if (adv) begin
			wz_s <= {wz_s[WZ-2:0], acc_s2[3] == '0};
		end
	end

	assign pt[0] = points.point_x;
	assign pt[1] = points.point_y;
	assign pt[2] = points.point_z;

	hpt_dot #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS), .ACC_WIDTH(AW)) u_dot (
		.clk    (clk),
		.en     (adv),
		.mat    (mat_q),
		.pt     (pt),
		.acc_s2 (acc_s2)
	);

	for (genvar k = 0; k < 3; k++) begin : g_lane
		hpt_div #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS), .ACC_WIDTH(AW)) u_div (
			.clk   (clk),
			.en    (adv),
			.num   (acc_s2[k]),
			.den   (acc_s2[3]),
			.quo_q (quo[k]),
			.sat_q (sat[k])
		);
	end

	// zero w forces zero coordinates and drops the saturation flag
	assign results.valid     = v_s[NS-1];
	assign results.w_is_zero = wz_s[WZ-1];
	assign results.out_x     = wz_s[WZ-1] ? '0 : quo[0];
	assign results.out_y     = wz_s[WZ-1] ? '0 : quo[1];
	assign results.out_z     = wz_s[WZ-1] ? '0 : quo[2];
	assign results.saturated = !wz_s[WZ-1] && (|sat);

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && points.action == ACT_LOAD) |=> !v_s[0])
		else $error("load beat entered the pipeline as a point");

	a_point_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(take && points.action == ACT_POINT) |=> v_s[0])
		else $error("accepted point beat lost at entry");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s))
		else $error("pipeline moved during a stall");

	a_wz_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.w_is_zero) |-> !results.saturated
			&& results.out_x == '0)
		else $error("zero w result not cleared");
endmodule

### sv/hpt_dot.sv
// Row dot products: registered products, then registered row sums.
module hpt_dot
	import hpt_pkg::*;
#(
	parameter int unsigned WORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned ACC_WIDTH  = 66
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [WORD_WIDTH-1:0] mat [MAT_ENTRIES],
	input  logic signed [WORD_WIDTH-1:0] pt [3],
	output logic signed [ACC_WIDTH-1:0]  acc_s2 [MAT_DIM]
);
	logic signed [2*WORD_WIDTH-1:0] prod_s1 [MAT_DIM][3];
	logic signed [WORD_WIDTH-1:0]   ofs_s1 [MAT_DIM];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < MAT_DIM; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= mat[r*MAT_DIM+c] * pt[c];
				end
				ofs_s1[r] <= mat[r*MAT_DIM+3];
			end
		end
	end

	// add the three products and the translation scaled to the fixed point
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < MAT_DIM; r++) begin
				acc_s2[r] <= ACC_WIDTH'(prod_s1[r][0]) + ACC_WIDTH'(prod_s1[r][1])
					+ ACC_WIDTH'(prod_s1[r][2]) + (ACC_WIDTH'(ofs_s1[r]) <<< FRAC_BITS);
			end
		end
	end
endmodule

### sv/hpt_div.sv
// Divider lane: signed num * 2^FRAC_BITS / den, one quotient bit per stage.
module hpt_div
	import hpt_pkg::*;
#(
	parameter int unsigned WORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned ACC_WIDTH  = 66
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [ACC_WIDTH-1:0]  num,
	input  logic signed [ACC_WIDTH-1:0]  den,
	output logic signed [WORD_WIDTH-1:0] quo_q,
	output logic                         sat_q
);
	localparam int unsigned NW = ACC_WIDTH + FRAC_BITS;
	localparam int unsigned CW = ACC_WIDTH + FRAC_BITS + WORD_WIDTH;

	logic [NW-1:0]        nmag_sa;
	logic [ACC_WIDTH-1:0] dmag_sa;
	logic                 neg_sa;

	logic [ACC_WIDTH-1:0]  rem_s [WORD_WIDTH+1];
	logic [ACC_WIDTH-1:0]  den_s [WORD_WIDTH+1];
	logic [WORD_WIDTH-1:0] low_s [WORD_WIDTH+1];
	logic [WORD_WIDTH-1:0] quo_s [WORD_WIDTH+1];
	logic                  big_s [WORD_WIDTH+1];
	logic                  neg_s [WORD_WIDTH+1];

	logic [ACC_WIDTH-1:0] nabs, dabs;
	logic [WORD_WIDTH-1:0] limit, qfin, qmag;
	logic                 ovf;

	assign nabs = num[ACC_WIDTH-1] ? ACC_WIDTH'(-num) : ACC_WIDTH'(num);
	assign dabs = den[ACC_WIDTH-1] ? ACC_WIDTH'(-den) : ACC_WIDTH'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_sa <= {nabs, FRAC_BITS'(0)};
			dmag_sa <= dabs;
			neg_sa  <= num[ACC_WIDTH-1] ^ den[ACC_WIDTH-1];
		end
	end

	// quotient fits WORD_WIDTH bits only when the numerator is below den << WORD_WIDTH
	always_ff @(posedge clk) begin
		if (en) begin
			big_s[0] <= CW'(nmag_sa) >= (CW'(dmag_sa) << WORD_WIDTH);
			rem_s[0] <= ACC_WIDTH'(nmag_sa >> WORD_WIDTH);
			low_s[0] <= nmag_sa[WORD_WIDTH-1:0];
			den_s[0] <= dmag_sa;
			quo_s[0] <= '0;
			neg_s[0] <= neg_sa;
		end
	end

	for (genvar i = 0; i < WORD_WIDTH; i++) begin : g_step
		logic [ACC_WIDTH:0] trial;
		logic               fits;
		assign trial = {rem_s[i], low_s[i][WORD_WIDTH-1]};
		assign fits  = trial >= {1'b0, den_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= fits ? ACC_WIDTH'(trial - {1'b0, den_s[i]})
					: ACC_WIDTH'(trial);
				quo_s[i+1] <= {quo_s[i][WORD_WIDTH-2:0], fits};
				low_s[i+1] <= low_s[i] << 1;
				den_s[i+1] <= den_s[i];
				big_s[i+1] <= big_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign limit = neg_s[WORD_WIDTH] ? {1'b1, (WORD_WIDTH-1)'(0)}
		: {1'b0, {(WORD_WIDTH-1){1'b1}}};
	assign qfin  = quo_s[WORD_WIDTH];
	assign ovf   = big_s[WORD_WIDTH] || (qfin > limit);
	assign qmag  = ovf ? limit : qfin;

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= neg_s[WORD_WIDTH] ? -qmag : qmag;
			sat_q <= ovf;
		end
	end
endmodule
